// ===== rtl/core/dense_matrix_multiply_core_assert.svh =====
// Assertion macros shared by the matrix multiply core modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DENSE_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define DENSE_MATRIX_MULTIPLY_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DMM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared widths, request codes and controller/datapath interface types
// for the dense matrix multiply core.
// ----------------------------------------------------------------------------
package dmm_pkg;

    localparam int MAX_DIM_DEF = 8;   // default largest matrix dimension
    localparam int IDX_W       = 3;   // row/column index width
    localparam int DIM_W       = 4;   // size register width
    localparam int ELEM_W      = 16;  // Q8.8 element
    localparam int PROD_W      = 32;  // Q16.16 single product
    localparam int SUM_W       = 35;  // Q19.16 dot product
    localparam int CMD_W       = 2;

    // Request codes
    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_a;       // store element into A
        logic             wr_b;       // store element into B
        logic             issue;      // read one A/B pair for the MAC
        logic             first;      // first product of a dot product
        logic             last_k;     // last product of a dot product
        logic             load;       // move finished sum to output register
        logic             last_elem;  // final element of the run
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } dmm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic acc_done;   // accumulator holds a finished sum
        logic out_free;   // output register can take a result this cycle
    } dmm_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/dmm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_ctrl
// Sequencer: accepts requests, routes element writes and walks i, j, k
// over the result matrix during a compute run.
// ----------------------------------------------------------------------------
`include "dense_matrix_multiply_core_assert.svh"

module dmm_ctrl #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [dmm_pkg::CMD_W-1:0]   cmd,
    input  wire logic [dmm_pkg::IDX_W-1:0]   row_index,
    input  wire logic [dmm_pkg::IDX_W-1:0]   col_index,
    input  wire logic [dmm_pkg::DIM_W-1:0]   m_rows,
    input  wire logic [dmm_pkg::DIM_W-1:0]   n_cols,
    input  wire logic [dmm_pkg::DIM_W-1:0]   k_inner,
    input  wire dmm_pkg::dmm_status_t        status_i,
    output dmm_pkg::dmm_cmd_t                cmd_o
);
    import dmm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WAIT  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic             accept;
    logic             in_range;
    logic             k_end;
    logic             i_end;
    logic             j_end;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // write index must fall inside the store
    assign in_range = ({1'b0, row_index} < DIM_W'(MAX_DIM)) &&
                      ({1'b0, col_index} < DIM_W'(MAX_DIM));

    // loop end flags against the configured sizes
    assign k_end = ({1'b0, k_reg} == (k_inner - DIM_W'(1)));
    assign j_end = ({1'b0, j_reg} == (n_cols - DIM_W'(1)));
    assign i_end = ({1'b0, i_reg} == (m_rows - DIM_W'(1)));

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        cmd_o           = '0;
        cmd_o.i         = i_reg;
        cmd_o.j         = j_reg;
        cmd_o.k         = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_WRITE_A: cmd_o.wr_a = in_range;
                        CMD_WRITE_B: cmd_o.wr_b = in_range;
                        CMD_COMPUTE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_ISSUE;
                        end
                        default: ;  // unused code, dropped
                    endcase
                end
            end
            ST_ISSUE:
            begin
                cmd_o.issue  = 1'b1;
                cmd_o.first  = (k_reg == '0);
                cmd_o.last_k = k_end;
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                cmd_o.last_elem = i_end && j_end;
                if (status_i.acc_done && status_i.out_free)
                begin
                    cmd_o.load = 1'b1;
                    if (i_end && j_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (j_end)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    `DMM_ASSERT_IMPL(a_load_when_ready, cmd_o.load, status_i.acc_done && status_i.out_free, "load without finished sum or free output")
    `DMM_ASSERT_IMPL(a_issue_in_bounds, cmd_o.issue, {1'b0, k_reg} < k_inner, "inner index beyond k_inner")
    `DMM_ASSERT_IMPL(a_write_on_accept, cmd_o.wr_a || cmd_o.wr_b, in_valid && in_ready, "store write without accepted request")

endmodule
`default_nettype wire

// ===== rtl/core/dmm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_datapath
// A and B element stores, multiply-accumulate pipeline and the result
// output register.
// ----------------------------------------------------------------------------
`include "dense_matrix_multiply_core_assert.svh"

module dmm_datapath #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dmm_pkg::dmm_cmd_t                  cmd_i,
    output dmm_pkg::dmm_status_t                    status_o,
    input  wire logic [dmm_pkg::IDX_W-1:0]          row_index,
    input  wire logic [dmm_pkg::IDX_W-1:0]          col_index,
    input  wire logic signed [dmm_pkg::ELEM_W-1:0]  element_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [dmm_pkg::IDX_W-1:0]               out_row,
    output logic [dmm_pkg::IDX_W-1:0]               out_col,
    output logic signed [dmm_pkg::SUM_W-1:0]        product_value,
    output logic                                    last_element
);
    import dmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] b_mem [DEPTH];

    logic [AW-1:0]            waddr;
    logic [AW-1:0]            raddr_a;
    logic [AW-1:0]            raddr_b;

    // stage 1: registered store reads
    logic signed [ELEM_W-1:0] rd_a_reg;
    logic signed [ELEM_W-1:0] rd_b_reg;
    logic                     v1_reg;
    logic                     first1_reg;
    logic                     lastk1_reg;

    // stage 2: product
    logic signed [PROD_W-1:0] prod_reg;
    logic                     v2_reg;
    logic                     first2_reg;
    logic                     lastk2_reg;

    // stage 3: accumulator
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    logic signed [SUM_W-1:0]  prod_ext;
    logic                     acc_done_reg, acc_done_next;

    // output register
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [SUM_W-1:0]  product_value_reg;
    logic                     last_reg;

    // store addresses, entry at row * MAX_DIM + col
    assign waddr   = AW'(row_index * MAX_DIM + col_index);
    assign raddr_a = AW'(cmd_i.i * MAX_DIM + cmd_i.k);
    assign raddr_b = AW'(cmd_i.k * MAX_DIM + cmd_i.j);

    // element stores: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd_i.wr_a)
        begin
            a_mem[waddr] <= element_value;
        end
        rd_a_reg <= a_mem[raddr_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.wr_b)
        begin
            b_mem[waddr] <= element_value;
        end
        rd_b_reg <= b_mem[raddr_b];
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        prod_reg <= rd_a_reg * rd_b_reg;
        acc_reg  <= acc_next;
    end

    assign prod_ext = {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // accumulate, restart on the first product of each sum
    always_comb
    begin
        acc_next      = acc_reg;
        acc_done_next = acc_done_reg;
        if (v2_reg)
        begin
            acc_next = first2_reg ? prod_ext : (acc_reg + prod_ext);
        end
        if (cmd_i.load)
        begin
            acc_done_next = 1'b0;
        end
        else if (v2_reg && lastk2_reg)
        begin
            acc_done_next = 1'b1;
        end
    end

    // pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            first1_reg   <= 1'b0;
            lastk1_reg   <= 1'b0;
            v2_reg       <= 1'b0;
            first2_reg   <= 1'b0;
            lastk2_reg   <= 1'b0;
            acc_done_reg <= 1'b0;
        end
        else
        begin
            v1_reg       <= cmd_i.issue;
            first1_reg   <= cmd_i.first;
            lastk1_reg   <= cmd_i.last_k;
            v2_reg       <= v1_reg;
            first2_reg   <= first1_reg;
            lastk2_reg   <= lastk1_reg;
            acc_done_reg <= acc_done_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_i.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            out_row_reg       <= cmd_i.i;
            out_col_reg       <= cmd_i.j;
            product_value_reg <= acc_reg;
            last_reg          <= cmd_i.last_elem;
        end
    end

    assign status_o.acc_done = acc_done_reg;
    assign status_o.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = product_value_reg;
    assign last_element  = last_reg;

    `DMM_ASSERT_IMPL(a_done_pipe_empty, acc_done_reg, !v1_reg && !v2_reg, "products in flight after sum finished")
    `DMM_ASSERT_IMPL(a_load_has_sum, cmd_i.load, acc_done_reg, "load without finished sum")
    `DMM_ASSERT_NEXT(a_sum_held, acc_done_reg && !cmd_i.load, acc_done_reg, "finished sum dropped before load")

endmodule
`default_nettype wire

// ===== rtl/core/dense_matrix_multiply_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dense_matrix_multiply_core
// Exact fixed-point C = A x B with Q8.8 elements and Q19.16 sums.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (valid/ready) write one element of A or B, or start a
//   compute run. A compute run emits m_rows*n_cols results in row-major
//   order on the output channel, last_element flagging the final one; no
//   request is taken until the last result is in the output register.
//   The A/B stores have one read port each, so one product enters the
//   multiply-accumulate pipeline per cycle while a sum is issued, and the
//   read, multiply and accumulate stages drain before the sum moves to the
//   output register.
//   The output register holds a result while the next sum is computed; a
//   stalled receiver holds the run once that sum is finished.
//   Size registers m_rows, n_cols, k_inner sit on the APB port at 0x0, 0x4,
//   0x8 (from pwdata[3:0]: write 0 reads back 1, above MAX_DIM clamps). Reset
//   returns sizes to MAX_DIM and the sequencer to idle; store contents are
//   undefined until written.
// ----------------------------------------------------------------------------

module dense_matrix_multiply_core #(
    parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [3:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // request channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [dmm_pkg::CMD_W-1:0]          cmd,
    input  wire logic [dmm_pkg::IDX_W-1:0]          row_index,
    input  wire logic [dmm_pkg::IDX_W-1:0]          col_index,
    input  wire logic signed [dmm_pkg::ELEM_W-1:0]  element_value,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [dmm_pkg::IDX_W-1:0]               out_row,
    output logic [dmm_pkg::IDX_W-1:0]               out_col,
    output logic signed [dmm_pkg::SUM_W-1:0]        product_value,
    output logic                                    last_element
);
    import dmm_pkg::*;

    localparam logic [1:0] REG_M_ROWS  = 2'd0;
    localparam logic [1:0] REG_N_COLS  = 2'd1;
    localparam logic [1:0] REG_K_INNER = 2'd2;

    logic [DIM_W-1:0] m_rows_reg;
    logic [DIM_W-1:0] n_cols_reg;
    logic [DIM_W-1:0] k_inner_reg;
    logic [DIM_W-1:0] wdata_clamped;
    logic [1:0]       reg_index;
    logic             reg_write;

    dmm_cmd_t         dp_cmd;
    dmm_status_t      dp_status;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign reg_write = psel && penable && pwrite && pready;

    // clamp a written size into 1..MAX_DIM
    always_comb
    begin
        wdata_clamped = pwdata[DIM_W-1:0];
        if (pwdata[DIM_W-1:0] == '0)
        begin
            wdata_clamped = DIM_W'(1);
        end
        else if (pwdata[DIM_W-1:0] > DIM_W'(MAX_DIM))
        begin
            wdata_clamped = DIM_W'(MAX_DIM);
        end
    end

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_rows_reg  <= DIM_W'(MAX_DIM);
            n_cols_reg  <= DIM_W'(MAX_DIM);
            k_inner_reg <= DIM_W'(MAX_DIM);
        end
        else if (reg_write)
        begin
            case (reg_index)
                REG_M_ROWS:  m_rows_reg  <= wdata_clamped;
                REG_N_COLS:  n_cols_reg  <= wdata_clamped;
                REG_K_INNER: k_inner_reg <= wdata_clamped;
                default: ;  // no register there
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (reg_index)
            REG_M_ROWS:  prdata = {{(32 - DIM_W){1'b0}}, m_rows_reg};
            REG_N_COLS:  prdata = {{(32 - DIM_W){1'b0}}, n_cols_reg};
            REG_K_INNER: prdata = {{(32 - DIM_W){1'b0}}, k_inner_reg};
            default:     prdata = '0;
        endcase
    end

    dmm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .row_index (row_index),
        .col_index (col_index),
        .m_rows    (m_rows_reg),
        .n_cols    (n_cols_reg),
        .k_inner   (k_inner_reg),
        .status_i  (dp_status),
        .cmd_o     (dp_cmd)
    );

    dmm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_i         (dp_cmd),
        .status_o      (dp_status),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last_element  (last_element)
    );

endmodule
`default_nettype wire
